// ===== hdl/cbd_pkg.sv =====
package cbd_pkg;

	// default widths and reset values
	localparam int unsigned SIZE_BITS_DEF = 64;
	localparam logic [15:0] MAX_LINE_RST  = 16'd8192;
	localparam logic [15:0] LINE_LEN_SAT  = 16'hFFFF;

	// decoder phases
	localparam int unsigned PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_SIZE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_EXT    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_BADHEX = 3'd2;
	localparam logic [PHASE_W-1:0] PH_OVF    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CEND   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_TRAIL  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

	// error codes
	localparam logic [3:0] ERR_NONE    = 4'd0;
	localparam logic [3:0] ERR_BARE_CR = 4'd1;
	localparam logic [3:0] ERR_NUL     = 4'd2;
	localparam logic [3:0] ERR_TOOLONG = 4'd3;
	localparam logic [3:0] ERR_BADHEX  = 4'd4;
	localparam logic [3:0] ERR_BADEND  = 4'd5;
	localparam logic [3:0] ERR_CLOSED  = 4'd6;
	localparam logic [3:0] ERR_OVF     = 4'd7;
	localparam logic [3:0] ERR_EXCESS  = 4'd8;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	// one result beat
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       body_done;
		logic [3:0] error_code;
	} res_t;

	// hex digit decode: {ok, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end
		return r;
	endfunction

endpackage

// ===== hdl/http_chunked_body_decoder.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    byte_value, stream_closed
// out      output     out_valid / out_stall  payload_valid, payload_byte, body_done, error_code
// cfg      input      cfg_valid / cfg_ready  cfg_data (max_line_length)
//
// One result beat per input beat; a new byte is taken every cycle while in_stall is low.
// Each byte passes the input register, then the decode step into the result register.
// The decode step (64-bit size decrement or hex shift, 16-bit line count) sets the clock.
// arst_n clears the decoder to the size-line phase and sets the line limit to 8192.
// out_stall backs up into in_stall only when both registers are full.
// cfg_ready is high only while both registers are empty.
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        stream_closed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        body_done,
	output logic [3:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          closed_s1;
	logic          free, adv, accept;
	cbd_pkg::res_t res, res_q;

	assign adv       = valid_s1 && free;
	assign in_stall  = valid_s1 && !free;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = !valid_s1 && !out_valid;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1   <= byte_value;
			closed_s1 <= stream_closed;
		end
	end

	cbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.byte_in   (byte_s1),
		.closed_in (closed_s1),
		.res       (res)
	);

	cbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.res_q     (res_q)
	);

	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign body_done     = res_q.body_done;
	assign error_code    = res_q.error_code;

endmodule

// ===== hdl/cbd_core.sv =====
module cbd_core #(
	parameter int unsigned SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               adv,
	input  logic [7:0]         byte_in,
	input  logic               closed_in,
	output cbd_pkg::res_t      res
);

	logic [cbd_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [SIZE_BITS-1:0]        chunk_q, chunk_d, chunk_dec;
	logic [15:0]                 line_len_q, line_len_d;
	logic [15:0]                 max_len_q;
	logic [3:0]                  err_q, err_d;
	logic                        cr_q, cr_d;

	// line framing results
	logic        lb_end, lb_err, lb_content, lb_cr;
	logic [3:0]  lb_code;
	logic [15:0] lb_len, len_inc;
	logic [4:0]  hex;

	logic pv, done;

	assign chunk_dec = chunk_q - 1'b1;
	assign hex       = cbd_pkg::hex_decode(byte_in);
	assign len_inc   = (line_len_q != cbd_pkg::LINE_LEN_SAT) ? line_len_q + 16'd1 : line_len_q;

	// frame one line byte: CRLF, NUL and length limit
	always_comb begin
		lb_end     = 1'b0;
		lb_err     = 1'b0;
		lb_content = 1'b0;
		lb_code    = cbd_pkg::ERR_NONE;
		lb_cr      = cr_q;
		lb_len     = line_len_q;
		if (cr_q) begin
			if (byte_in == cbd_pkg::CH_LF) begin
				lb_end = 1'b1;
				lb_cr  = 1'b0;
			end else begin
				lb_err  = 1'b1;
				lb_code = cbd_pkg::ERR_BARE_CR;
			end
		end else if (byte_in == cbd_pkg::CH_NUL) begin
			lb_err  = 1'b1;
			lb_code = cbd_pkg::ERR_NUL;
		end else begin
			lb_cr  = (byte_in == cbd_pkg::CH_CR);
			lb_len = len_inc;
			if (len_inc >= max_len_q) begin
				lb_err  = 1'b1;
				lb_code = cbd_pkg::ERR_TOOLONG;
			end else begin
				lb_content = !lb_cr;
			end
		end
	end

	// next state for one item
	always_comb begin
		phase_d    = phase_q;
		chunk_d    = chunk_q;
		line_len_d = line_len_q;
		err_d      = err_q;
		cr_d       = cr_q;
		pv         = 1'b0;
		done       = 1'b0;
		if (err_q == cbd_pkg::ERR_NONE) begin
			priority if (closed_in) begin
				if (phase_q != cbd_pkg::PH_DONE) err_d = cbd_pkg::ERR_CLOSED;
			end else if (phase_q == cbd_pkg::PH_DONE) begin
				err_d = cbd_pkg::ERR_EXCESS;
			end else begin
				unique case (phase_q)
					cbd_pkg::PH_DATA: begin
						pv      = 1'b1;
						chunk_d = chunk_dec;
						if (chunk_dec == '0) begin
							phase_d    = cbd_pkg::PH_CEND;
							line_len_d = 16'd0;
						end
					end
					cbd_pkg::PH_CEND: begin
						if (!cr_q && byte_in != cbd_pkg::CH_CR && byte_in != cbd_pkg::CH_NUL) begin
							err_d = cbd_pkg::ERR_BADEND;
						end else begin
							cr_d       = lb_cr;
							line_len_d = lb_len;
							if (lb_err) err_d = lb_code;
							if (lb_end) begin
								phase_d    = cbd_pkg::PH_SIZE;
								chunk_d    = '0;
								line_len_d = 16'd0;
							end
						end
					end
					cbd_pkg::PH_TRAIL: begin
						cr_d       = lb_cr;
						line_len_d = lb_len;
						if (lb_err) err_d = lb_code;
						if (lb_end) begin
							// an empty line holds only its CR
							if (line_len_q == 16'd1) begin
								phase_d = cbd_pkg::PH_DONE;
								done    = 1'b1;
							end
							line_len_d = 16'd0;
						end
					end
					default: begin
						// size line and its extension
						cr_d       = lb_cr;
						line_len_d = lb_len;
						if (lb_err) err_d = lb_code;
						if (lb_end) begin
							if (phase_q == cbd_pkg::PH_BADHEX) begin
								err_d = cbd_pkg::ERR_BADHEX;
							end else if (phase_q == cbd_pkg::PH_OVF) begin
								err_d = cbd_pkg::ERR_OVF;
							end else begin
								phase_d = (chunk_q == '0) ? cbd_pkg::PH_TRAIL : cbd_pkg::PH_DATA;
							end
							line_len_d = 16'd0;
						end else if (lb_content && phase_q == cbd_pkg::PH_SIZE) begin
							if (byte_in == cbd_pkg::CH_SEMI || byte_in == cbd_pkg::CH_SPACE) begin
								phase_d = cbd_pkg::PH_EXT;
							end else if (!hex[4]) begin
								phase_d = cbd_pkg::PH_BADHEX;
							end else if (chunk_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								phase_d = cbd_pkg::PH_OVF;
							end else begin
								chunk_d = {chunk_q[SIZE_BITS-5:0], hex[3:0]};
							end
						end
					end
				endcase
			end
		end
	end

	// drop everything but the code once an error stands
	always_comb begin
		res.error_code    = err_d;
		res.payload_valid = (err_d == cbd_pkg::ERR_NONE) && pv;
		res.payload_byte  = ((err_d == cbd_pkg::ERR_NONE) && pv) ? byte_in : 8'd0;
		res.body_done     = (err_d == cbd_pkg::ERR_NONE) && done;
	end

	// advance decoder state on each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cbd_pkg::PH_SIZE;
			chunk_q    <= '0;
			line_len_q <= 16'd0;
			err_q      <= cbd_pkg::ERR_NONE;
			cr_q       <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			chunk_q    <= chunk_d;
			line_len_q <= line_len_d;
			err_q      <= err_d;
			cr_q       <= cr_d;
		end
	end

	// line length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= cbd_pkg::MAX_LINE_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != cbd_pkg::ERR_NONE |=> err_q == $past(err_q))
		else $error("sticky error changed");

	a_err_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && err_q != cbd_pkg::ERR_NONE |-> res.error_code == err_q && !res.payload_valid)
		else $error("standing error not repeated");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cbd_pkg::PH_DATA |-> chunk_q != '0)
		else $error("data phase with empty chunk");

	a_data_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cbd_pkg::PH_DATA |-> line_len_q == 16'd0 && !cr_q)
		else $error("line state left over in data phase");

endmodule

// ===== hdl/cbd_out_stage.sv =====
module cbd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  cbd_pkg::res_t res,
	input  logic          out_stall,
	output logic          out_valid,
	output logic          free,
	output cbd_pkg::res_t res_q
);

	logic valid_q;

	// slot can take a result when empty or being drained
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== tb/sv/http_chunked_body_decoder_tb.sv =====
module http_chunked_body_decoder_tb;

	localparam int unsigned SZ          = cbd_pkg::SIZE_BITS_DEF;
	localparam int unsigned HOLD_LONG   = 64;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned MAX_PRINTS  = 30;
	localparam int          DIR_ROWS    = 19;

	typedef enum logic [1:0] {FR_TEXT, FR_CR, FR_EOL, FR_FAIL} frame_ev_t;

	// one input beat, with an optional hand-written expectation
	typedef struct packed {
		logic [7:0]    b;
		logic          closed;
		logic          typed;
		cbd_pkg::res_t want;
	} stim_row_t;

	localparam cbd_pkg::res_t NO_RESULT = '0;

	// directed rows: extension forms, payload extremes, CR/LF/NUL as data
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{"0",               1'b0, 1'b1, NO_RESULT},
		'{"2",               1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_SPACE, 1'b0, 1'b0, NO_RESULT},
		'{"x",               1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_CR,    1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_LF,    1'b0, 1'b0, NO_RESULT},
		'{8'h00,             1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, cbd_pkg::ERR_NONE}},
		'{8'hFF,             1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, cbd_pkg::ERR_NONE}},
		'{cbd_pkg::CH_CR,    1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_LF,    1'b0, 1'b0, NO_RESULT},
		'{"3",               1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_SEMI,  1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_CR,    1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_LF,    1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_CR,    1'b0, 1'b1,
			'{1'b1, cbd_pkg::CH_CR, 1'b0, cbd_pkg::ERR_NONE}},
		'{cbd_pkg::CH_LF,    1'b0, 1'b1,
			'{1'b1, cbd_pkg::CH_LF, 1'b0, cbd_pkg::ERR_NONE}},
		'{cbd_pkg::CH_NUL,   1'b0, 1'b1,
			'{1'b1, cbd_pkg::CH_NUL, 1'b0, cbd_pkg::ERR_NONE}},
		'{cbd_pkg::CH_CR,    1'b0, 1'b0, NO_RESULT},
		'{cbd_pkg::CH_LF,    1'b0, 1'b0, NO_RESULT}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_value    = 8'h00;
	logic        stream_closed = 1'b0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        body_done;
	logic [3:0]  error_code;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data      = 16'h0000;

	// shadow decoder state
	logic [cbd_pkg::PHASE_W-1:0] dec_phase     = cbd_pkg::PH_SIZE;
	logic [SZ-1:0]               dec_remaining = '0;
	logic [15:0]                 dec_line_len  = '0;
	logic [3:0]                  dec_error     = cbd_pkg::ERR_NONE;
	logic                        dec_cr_pend   = 1'b0;
	logic [15:0]                 dec_max_line  = cbd_pkg::MAX_LINE_RST;

	cbd_pkg::res_t expected_q [$];
	stim_row_t     beat_note_q [$];

	int unsigned n_sent     = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked  = 0;
	int unsigned n_errors   = 0;
	int unsigned n_cycles   = 0;
	bit          idling_on  = 1'b1;
	bit          hold_req   = 1'b0;

	http_chunked_body_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_value   (byte_value),
		.stream_closed(stream_closed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_valid(payload_valid),
		.payload_byte (payload_byte),
		.body_done    (body_done),
		.error_code   (error_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin : reset_seq
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int hex_digit_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	// any line byte that keeps the line going: no NUL, no CR
	function automatic logic [7:0] line_text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == cbd_pkg::CH_CR);
		return c;
	endfunction

	// CRLF framing, NUL check and line length limit
	function automatic frame_ev_t frame_byte(input logic [7:0] b);
		if (dec_cr_pend) begin
			if (b == cbd_pkg::CH_LF) begin
				dec_cr_pend = 1'b0;
				return FR_EOL;
			end
			dec_error = cbd_pkg::ERR_BARE_CR;
			return FR_FAIL;
		end
		if (b == cbd_pkg::CH_NUL) begin
			dec_error = cbd_pkg::ERR_NUL;
			return FR_FAIL;
		end
		if (b == cbd_pkg::CH_CR) dec_cr_pend = 1'b1;
		if (dec_line_len != cbd_pkg::LINE_LEN_SAT) dec_line_len++;
		if (dec_line_len >= dec_max_line) begin
			dec_error = cbd_pkg::ERR_TOOLONG;
			return FR_FAIL;
		end
		return dec_cr_pend ? FR_CR : FR_TEXT;
	endfunction

	// advance the shadow decoder by one received byte
	function automatic cbd_pkg::res_t decode_step(input logic [7:0] b, input logic closed);
		cbd_pkg::res_t r;
		frame_ev_t     ev;
		int            d;
		r = '0;
		if (dec_error == cbd_pkg::ERR_NONE) begin
			if (closed) begin
				if (dec_phase != cbd_pkg::PH_DONE) dec_error = cbd_pkg::ERR_CLOSED;
			end else if (dec_phase == cbd_pkg::PH_DONE) begin
				dec_error = cbd_pkg::ERR_EXCESS;
			end else if (dec_phase == cbd_pkg::PH_DATA) begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				dec_remaining = dec_remaining - 1'b1;
				if (dec_remaining == '0) begin
					dec_phase = cbd_pkg::PH_CEND;
					dec_line_len = '0;
				end
			end else if (dec_phase == cbd_pkg::PH_CEND) begin
				if (!dec_cr_pend && b != cbd_pkg::CH_CR && b != cbd_pkg::CH_NUL) begin
					dec_error = cbd_pkg::ERR_BADEND;
				end else if (frame_byte(b) == FR_EOL) begin
					dec_phase = cbd_pkg::PH_SIZE;
					dec_remaining = '0;
					dec_line_len = '0;
				end
			end else if (dec_phase == cbd_pkg::PH_TRAIL) begin
				if (frame_byte(b) == FR_EOL) begin
					if (dec_line_len == 16'd1) begin
						dec_phase = cbd_pkg::PH_DONE;
						r.body_done = 1'b1;
					end
					dec_line_len = '0;
				end
			end else begin
				ev = frame_byte(b);
				if (ev == FR_EOL) begin
					if (dec_phase == cbd_pkg::PH_BADHEX) dec_error = cbd_pkg::ERR_BADHEX;
					else if (dec_phase == cbd_pkg::PH_OVF) dec_error = cbd_pkg::ERR_OVF;
					else dec_phase = (dec_remaining == '0) ? cbd_pkg::PH_TRAIL
						: cbd_pkg::PH_DATA;
					dec_line_len = '0;
				end else if (ev == FR_TEXT && dec_phase == cbd_pkg::PH_SIZE) begin
					if (b == cbd_pkg::CH_SEMI || b == cbd_pkg::CH_SPACE) begin
						dec_phase = cbd_pkg::PH_EXT;
					end else begin
						d = hex_digit_val(b);
						if (d < 0) dec_phase = cbd_pkg::PH_BADHEX;
						else if (dec_remaining[SZ-1 -: 4] != 4'd0) dec_phase = cbd_pkg::PH_OVF;
						else dec_remaining = {dec_remaining[SZ-5:0], 4'(d)};
					end
				end
			end
		end
		if (dec_error != cbd_pkg::ERR_NONE) r = '0;
		r.error_code = dec_error;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got_v,
			input logic [7:0] want_v);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch on result %0d: %s got %h expected %h",
				n_checked, what, got_v, want_v);
	endtask

	// predict on every accepted input beat, check every accepted result beat
	always @(posedge clk) begin : scoreboard
		cbd_pkg::res_t pred, got, want;
		stim_row_t     note;
		if (arst_n && in_valid && !in_stall) begin
			pred = decode_step(byte_value, stream_closed);
			note = beat_note_q[0];
			beat_note_q.delete(0);
			expected_q = {expected_q, (note.typed ? note.want : pred)};
			n_accepted++;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {payload_valid, payload_byte, body_done, error_code};
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with nothing expected", 8'(got), 8'h00);
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (got.payload_valid !== want.payload_valid)
					report_mismatch("payload_valid", 8'(got.payload_valid),
						8'(want.payload_valid));
				if (got.payload_byte !== want.payload_byte)
					report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
				if (got.body_done !== want.body_done)
					report_mismatch("body_done", 8'(got.body_done), 8'(want.body_done));
				if (got.error_code !== want.error_code)
					report_mismatch("error_code", 8'(got.error_code), 8'(want.error_code));
			end
			n_checked++;
		end
	end

	// receiver: short random stall bursts, plus one long hold-off on request
	initial begin : sink_pacing
		int unsigned burst_left, hold_left;
		burst_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LONG;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left != 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				n_cycles, expected_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// offer one beat, maybe after an idle burst, and hold it until taken
	task automatic send_beat(input logic [7:0] b, input logic closed = 1'b0,
			input logic typed = 1'b0, input cbd_pkg::res_t want = '0);
		stim_row_t note;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		note = '{b, closed, typed, want};
		beat_note_q = {beat_note_q, note};
		in_valid <= 1'b1;
		byte_value <= b;
		stream_closed <= closed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// drop valid so the last beat is not offered again, then drain
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_checked < n_accepted) @(posedge clk);
	endtask

	task automatic write_line_limit(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		dec_max_line = v;
	endtask

	// size line: optional leading zeros, mixed-case digits, optional extension;
	// budget is the number of bytes the line may hold before its CR
	task automatic send_size_line(input logic [63:0] n, input int budget);
		int nd, lead, room, ext_len, i;
		nd = 0;
		while (nd < 16 && (n >> (4 * nd)) != 64'd0) nd++;
		lead = (budget > nd) ? $urandom_range(0, (budget - nd > 2) ? 2 : budget - nd) : 0;
		repeat (lead) send_beat("0");
		for (i = nd - 1; i >= 0; i--) send_beat(hex_char(n[4 * i +: 4]));
		room = budget - lead - nd;
		if (room > 0 && $urandom_range(0, 2) == 0) begin
			send_beat($urandom_range(0, 1) ? cbd_pkg::CH_SEMI : cbd_pkg::CH_SPACE);
			// sometimes fill the line right up to the limit
			if (room <= 64 && $urandom_range(0, 3) == 0)
				ext_len = room - 1;
			else
				ext_len = $urandom_range(0, (room - 1 > 10) ? 10 : room - 1);
			repeat (ext_len) send_beat(line_text_byte());
		end
		send_beat(cbd_pkg::CH_CR);
		send_beat(cbd_pkg::CH_LF);
	endtask

	initial begin : stimulus
		int unsigned next_cfg_at, n;
		int          budget, i;
		bit          hold_done;
		logic [3:0]  kind;
		logic [7:0]  b;
		next_cfg_at = 150;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		write_line_limit(16'hFFFF);

		// directed rows
		for (i = 0; i < DIR_ROWS; i++)
			send_beat(DIR_TABLE[i].b, DIR_TABLE[i].closed, DIR_TABLE[i].typed, DIR_TABLE[i].want);

		// random chunks of one long body, line limit changed between chunks
		while (n_sent < 1240) begin
			if (n_sent >= next_cfg_at) begin
				wait_results_drained();
				case ($urandom_range(0, 4))
					0: write_line_limit(16'hFFFF);
					1: write_line_limit(cbd_pkg::MAX_LINE_RST);
					2: write_line_limit(16'($urandom_range(3, 8)));
					3: write_line_limit(16'($urandom_range(9, 64)));
					default: write_line_limit(16'($urandom_range(65, 4000)));
				endcase
				next_cfg_at += 180;
			end
			if (!hold_done && n_sent >= 500) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			idling_on = (n_sent < 1100) && ((n_sent / 120) % 4 != 3);
			budget = int'(dec_max_line) - 2;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			if (budget < 2 && n > 15) n = $urandom_range(1, 15);
			send_size_line(n, budget);
			repeat (n) send_beat(8'($urandom_range(0, 255)));
			send_beat(cbd_pkg::CH_CR);
			send_beat(cbd_pkg::CH_LF);
		end

		// close out with one ending, clean or broken, picked at random
		idling_on = 1'b0;
		wait_results_drained();
		kind = 4'($urandom_range(1, 8));
		case (kind)
			cbd_pkg::ERR_TOOLONG: write_line_limit(16'($urandom_range(0, 10)));
			cbd_pkg::ERR_EXCESS: write_line_limit($urandom_range(0, 1) ? 16'd2 :
				16'($urandom_range(3, 65535)));
			default: write_line_limit(16'($urandom_range(64, 65535)));
		endcase
		budget = int'(dec_max_line) - 2;
		case (kind)
			cbd_pkg::ERR_BARE_CR: begin
				send_beat(hex_char(4'($urandom_range(0, 15))));
				send_beat(cbd_pkg::CH_CR);
				do b = 8'($urandom_range(0, 255)); while (b == cbd_pkg::CH_LF);
				send_beat(b);
			end
			cbd_pkg::ERR_NUL: begin
				if ($urandom_range(0, 1)) begin
					send_beat("1");
				end else begin
					send_size_line(1, budget);
					send_beat(8'($urandom_range(0, 255)));
				end
				send_beat(cbd_pkg::CH_NUL);
			end
			cbd_pkg::ERR_TOOLONG: begin
				repeat (12) send_beat("0");
				send_beat(cbd_pkg::CH_CR);
				send_beat(cbd_pkg::CH_LF);
			end
			cbd_pkg::ERR_BADHEX: begin
				send_beat("1");
				do b = 8'($urandom_range(1, 255));
				while (hex_digit_val(b) >= 0 || b == cbd_pkg::CH_SEMI
					|| b == cbd_pkg::CH_SPACE || b == cbd_pkg::CH_CR);
				send_beat(b);
				send_beat(cbd_pkg::CH_CR);
				send_beat(cbd_pkg::CH_LF);
			end
			cbd_pkg::ERR_BADEND: begin
				send_size_line(1, budget);
				send_beat(8'($urandom_range(0, 255)));
				do b = 8'($urandom_range(1, 255)); while (b == cbd_pkg::CH_CR);
				send_beat(b);
			end
			cbd_pkg::ERR_CLOSED: begin
				send_size_line(2, budget);
				send_beat(8'($urandom_range(0, 255)));
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			cbd_pkg::ERR_OVF: begin
				// seventeen significant digits push the size past its width
				send_beat(hex_char(4'($urandom_range(1, 15))));
				repeat (16) send_beat(hex_char(4'($urandom_range(0, 15))));
				send_beat(cbd_pkg::CH_CR);
				send_beat(cbd_pkg::CH_LF);
			end
			default: begin
				// last chunk, trailer lines, empty line, closes, then one byte too many
				send_size_line(0, budget);
				if (budget > 0) begin
					repeat ($urandom_range(0, 2)) begin
						repeat ($urandom_range(1, (budget > 12) ? 12 : budget))
							send_beat(line_text_byte());
						send_beat(cbd_pkg::CH_CR);
						send_beat(cbd_pkg::CH_LF);
					end
				end
				send_beat(cbd_pkg::CH_CR);
				send_beat(cbd_pkg::CH_LF);
				repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b1);
				send_beat(8'($urandom_range(0, 255)));
			end
		endcase

		// error must stick through whatever follows
		repeat (8) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		wait_results_drained();
		repeat (6) @(posedge clk);
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
